// ===== design/tlne_pkg.sv =====
// Shared types and constants for the text line-number / escape filter.
// Depends on nothing; imported by tlne_digits and the top level.
package tlne_pkg;

  // Input and output payloads
  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_SHOW_LINE_ENDS = 2'd0;
  localparam cfg_index_t CFG_SHOW_TAB_CHARS = 2'd1;
  localparam cfg_index_t CFG_NUMBER_LINES   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_PAD,
    S_DIGIT,
    S_TAB,
    S_BODY1,
    S_BODY2
  } tlne_state_t;

  // Number field is right-justified to this many columns
  localparam int PAD_WIDTH = 6;
  localparam int PAD_CNT_W = 3;

  // ASCII codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CAP_I  = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5E;

endpackage

// ===== design/tlne_digits.sv =====
// Decimal line counter: BCD digit registers with a one-digit-per-cycle
// carry walk, a read port and a significant-digit count. Uses tlne_pkg.
module tlne_digits #(
  parameter int DIGITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         inc_start,
  input  logic [$clog2(DIGITS)-1:0]    rd_idx,
  output logic [3:0]                   rd_digit,
  output logic [$clog2(DIGITS+1)-1:0]  sig,
  output logic                         busy
);
  import tlne_pkg::*;

  localparam int IW = $clog2(DIGITS);
  localparam int SW = $clog2(DIGITS + 1);

  logic [3:0]    digit [DIGITS];
  logic [IW-1:0] walk;
  logic [IW-1:0] addr;
  logic          all_nine;

  // single read port, shared between the carry walk and the emitter
  assign addr     = busy ? walk : rd_idx;
  assign rd_digit = digit[addr];

  always_comb begin
    all_nine = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (digit[i] != 4'd9) all_nine = 1'b0;
    end
  end

  // count of significant digits, at least one
  always_comb begin
    sig = SW'(1);
    for (int i = 0; i < DIGITS; i++) begin
      if (digit[i] != 4'd0) sig = SW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < DIGITS; i++) begin
        digit[i] <= (i == 0) ? 4'd1 : 4'd0;
      end
    end else if (busy) begin
      if (rd_digit >= 4'd9) begin
        digit[walk] <= 4'd0;
      end else begin
        digit[walk] <= rd_digit + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      walk <= '0;
    end else if (busy) begin
      if (rd_digit < 4'd9 || walk == IW'(DIGITS - 1)) begin
        busy <= 1'b0;
      end
      walk <= walk + IW'(1);
    end else if (inc_start && !all_nine) begin
      // saturated counter stays put
      busy <= 1'b1;
      walk <= '0;
    end
  end

endmodule

// ===== design/text_line_number_escape_filter_unit.sv =====
// Text filter: optional line numbers, '$' before newlines, '^I' for tabs.
// An input transfer moves the sequencer to S_PREP, and the first output byte is registered after it.
// An item yields 1 to DIGITS+3 output bytes; a new item is taken only once the sequencer
// is idle and any counter carry walk after a numbered newline is done.
// Output bytes leave the sequencer one per cycle, unless out_ready stalls them, through a single output register.
// Reset (rst, sync, high): config registers and out_valid cleared, counter at one, line start, idle.
module text_line_number_escape_filter_unit #(
  parameter int DIGITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  tlne_pkg::cfg_index_t  cfg_index,
  input  logic                  cfg_data,
  // input byte stream
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tlne_pkg::in_item_t    in_item,
  // output byte stream
  output logic                  out_valid,
  input  logic                  out_ready,
  output tlne_pkg::out_item_t   out_item
);
  import tlne_pkg::*;

  localparam int IW = $clog2(DIGITS);
  localparam int SW = $clog2(DIGITS + 1);

  // Configuration registers
  logic show_line_ends;
  logic show_tab_chars;
  logic number_lines;

  always_ff @(posedge clk) begin
    if (rst) begin
      show_line_ends <= 1'b0;
      show_tab_chars <= 1'b0;
      number_lines   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHOW_LINE_ENDS: show_line_ends <= cfg_data;
        CFG_SHOW_TAB_CHARS: show_tab_chars <= cfg_data;
        CFG_NUMBER_LINES:   number_lines   <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Sequencer state and item registers
  tlne_state_t          state, state_next;
  logic [7:0]           byte_q;
  logic                 at_line_start, at_line_start_next;
  logic [PAD_CNT_W-1:0] pad_cnt, pad_cnt_next;
  logic [IW-1:0]        dig_idx, dig_idx_next;
  logic                 out_valid_next;
  out_item_t            out_item_next;

  logic                 in_xfer;
  logic                 can_load;
  logic                 inc_start;
  logic                 cnt_busy;
  logic [3:0]           rd_digit;
  logic [SW-1:0]        sig;
  logic                 is_nl, ends_nl, tabs_tab;

  // Counter: the shared unit; it walks the carry one digit per cycle and
  // serves the emitter's digit reads through the same port.
  tlne_digits #(
    .DIGITS (DIGITS)
  ) u_digits (
    .clk       (clk),
    .rst       (rst),
    .clear     (in_xfer && in_item.file_start),
    .inc_start (inc_start),
    .rd_idx    (dig_idx),
    .rd_digit  (rd_digit),
    .sig       (sig),
    .busy      (cnt_busy)
  );

  // new item only once the previous one is out and the counter is settled
  assign in_ready = (state == S_IDLE) && !cnt_busy;
  assign in_xfer  = in_valid && in_ready;
  // output register free, or being drained this cycle
  assign can_load = !out_valid || out_ready;

  assign is_nl    = (byte_q == CH_NL);
  assign ends_nl  = show_line_ends && is_nl;
  assign tabs_tab = show_tab_chars && (byte_q == CH_TAB);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      at_line_start <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      at_line_start <= at_line_start_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) byte_q <= in_item.in_byte;
    pad_cnt  <= pad_cnt_next;
    dig_idx  <= dig_idx_next;
    out_item <= out_item_next;
  end

  always_comb begin
    state_next         = state;
    at_line_start_next = at_line_start;
    pad_cnt_next       = pad_cnt;
    dig_idx_next       = dig_idx;
    out_valid_next     = out_valid && !out_ready;
    out_item_next      = out_item;
    inc_start          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_PREP;
          // a new file restarts numbering on this byte
          if (in_item.file_start) at_line_start_next = 1'b1;
        end
      end

      S_PREP: begin
        if (number_lines && at_line_start) begin
          at_line_start_next = 1'b0;
          dig_idx_next       = IW'(sig - SW'(1));
          if (int'(sig) < PAD_WIDTH) begin
            pad_cnt_next = PAD_CNT_W'(PAD_WIDTH - int'(sig));
            state_next   = S_PAD;
          end else begin
            state_next = S_DIGIT;
          end
        end else begin
          state_next = S_BODY1;
        end
        // a numbered newline opens the next line
        if (number_lines && is_nl) at_line_start_next = 1'b1;
      end

      S_PAD: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          out_item_next  = '{out_byte: CH_SPACE, run_last: 1'b0};
          pad_cnt_next   = pad_cnt - PAD_CNT_W'(1);
          if (pad_cnt == PAD_CNT_W'(1)) state_next = S_DIGIT;
        end
      end

      S_DIGIT: begin
        // most significant digit first
        if (can_load) begin
          out_valid_next = 1'b1;
          out_item_next  = '{out_byte: CH_ZERO | {4'd0, rd_digit}, run_last: 1'b0};
          if (dig_idx == '0) begin
            state_next = S_TAB;
          end else begin
            dig_idx_next = dig_idx - IW'(1);
          end
        end
      end

      S_TAB: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          out_item_next  = '{out_byte: CH_TAB, run_last: 1'b0};
          state_next     = S_BODY1;
        end
      end

      S_BODY1: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          // digits are out; count the newline now
          inc_start      = number_lines && is_nl;
          if (ends_nl) begin
            out_item_next = '{out_byte: CH_DOLLAR, run_last: 1'b0};
            state_next    = S_BODY2;
          end else if (tabs_tab) begin
            out_item_next = '{out_byte: CH_CARET, run_last: 1'b0};
            state_next    = S_BODY2;
          end else begin
            out_item_next = '{out_byte: byte_q, run_last: 1'b1};
            state_next    = S_IDLE;
          end
        end
      end

      S_BODY2: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          out_item_next  = '{out_byte: ends_nl ? CH_NL : CH_CAP_I, run_last: 1'b1};
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Assertions

  // an accepted item is worked on; no second transfer right behind it
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("input taken while previous item still in progress");

  // digit reads never collide with the carry walk on the shared read port
  a_no_read_during_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> !cnt_busy)
    else $error("digit emitted while counter carry walk active");

  // a stalled output byte stays offered with the same payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("output byte dropped or changed while waiting");

  // walk only ever starts from the body stage after the number went out
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    $rose(cnt_busy) |-> (state == S_BODY2 || state == S_IDLE))
    else $error("counter walk started outside the body stage");

endmodule
